[rtl/core/gel_pkg.sv]
package gel_pkg;

   localparam int HIST_BINS_DEFAULT = 64;
   localparam int THRESH_W = 14;
   localparam int BURST_W = 16;
   localparam int COUNT_W = 32;
   localparam int CSR_INDEX_W = 1;

   localparam logic [THRESH_W-1:0] PROB_SCALE = 14'd10000;

   typedef enum logic [1:0] {
      OP_STEP = 2'd0,
      OP_HOLD = 2'd1,
      OP_READ = 2'd2
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GOOD_TO_BAD = 1'd0,
      CSR_BAD_TO_GOOD = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]          opcode;
      logic [THRESH_W-1:0] random_value;
      logic [5:0]          bin_index;
   } req_type;

   typedef struct packed {
      logic               channel_good;
      logic [COUNT_W-1:0] bin_count;
   } rsp_type;

   typedef struct packed {
      logic incr;
      logic read;
      logic good;
   } hist_cmd_type;

endpackage

[rtl/core/gel_state.sv]
module gel_state #(
   parameter int HIST_BINS = gel_pkg::HIST_BINS_DEFAULT,
   parameter int ADDR_W = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  gel_pkg::req_type              req,
   input  logic [gel_pkg::THRESH_W-1:0]  good_to_bad_threshold,
   input  logic [gel_pkg::THRESH_W-1:0]  bad_to_good_threshold,
   output gel_pkg::hist_cmd_type         cmd,
   output logic [ADDR_W-1:0]             addr
);
   import gel_pkg::*;

   logic               good_ff, good_in;
   logic [BURST_W-1:0] burst_ff, burst_in;
   logic [BURST_W-1:0] bin_wide;
   logic               loss, close, read_hit;

   always_comb begin
      good_in = good_ff;
      burst_in = burst_ff;
      loss = 1'b0;
      close = 1'b0;
      read_hit = 1'b0;
      bin_wide = BURST_W'(req.bin_index);
      case (req.opcode)
         OP_STEP: begin
            if (good_ff) begin
               if (req.random_value < good_to_bad_threshold) begin
                  good_in = 1'b0;
                  loss = 1'b1;
               end
            end else if (req.random_value < bad_to_good_threshold) begin
               good_in = 1'b1;
               close = 1'b1;
            end else begin
               loss = 1'b1;
            end
         end
         OP_HOLD: loss = !good_ff;
         OP_READ: read_hit = bin_wide < BURST_W'(HIST_BINS);
         default: ;
      endcase
      if (loss && burst_ff != '1) begin
         burst_in = burst_ff + 1'b1;
      end
      if (close) begin
         burst_in = '0;
      end
      cmd.incr = close && burst_ff != '0 && burst_ff < BURST_W'(HIST_BINS);
      cmd.read = read_hit;
      cmd.good = good_in;
      addr = close ? burst_ff[ADDR_W-1:0] : bin_wide[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         good_ff <= 1'b1;
         burst_ff <= '0;
      end else if (fire) begin
         good_ff <= good_in;
         burst_ff <= burst_in;
      end
   end

endmodule

[rtl/core/gel_hist.sv]
module gel_hist #(
   parameter int HIST_BINS = gel_pkg::HIST_BINS_DEFAULT,
   parameter int ADDR_W = 6
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  logic                         advance,
   input  gel_pkg::hist_cmd_type        cmd,
   input  logic [ADDR_W-1:0]            addr,
   output logic                         clear_busy,
   output logic                         b_valid,
   output gel_pkg::rsp_type             b_rsp
);
   import gel_pkg::*;

   logic [COUNT_W-1:0] mem [HIST_BINS];
   logic [COUNT_W-1:0] rd_q_ff;

   logic               clr_busy_ff;
   logic [ADDR_W-1:0]  clr_addr_ff;

   logic               b_valid_ff, b_valid_in;
   logic               b_incr_ff, b_read_ff, b_good_ff;
   logic [ADDR_W-1:0]  b_addr_ff;
   logic               b_fwd_ff;
   logic [COUNT_W-1:0] b_fwd_data_ff;

   logic [COUNT_W-1:0] cur, inc_data;
   logic               b_wr, wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [COUNT_W-1:0] wr_data;

   // the write issued alongside a load is not yet visible to that load's read
   assign cur = b_fwd_ff ? b_fwd_data_ff : rd_q_ff;
   assign inc_data = (cur == '1) ? cur : cur + 1'b1;
   assign b_wr = b_valid_ff && advance && b_incr_ff;

   assign wr_en = clr_busy_ff || b_wr;
   assign wr_addr = clr_busy_ff ? clr_addr_ff : b_addr_ff;
   assign wr_data = clr_busy_ff ? '0 : inc_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (load) begin
         rd_q_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(HIST_BINS - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      if (load) begin
         b_valid_in = 1'b1;
      end else if (advance) begin
         b_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         b_incr_ff <= cmd.incr;
         b_read_ff <= cmd.read;
         b_good_ff <= cmd.good;
         b_addr_ff <= addr;
         b_fwd_ff <= b_wr && (b_addr_ff == addr);
         b_fwd_data_ff <= inc_data;
      end
   end

   assign clear_busy = clr_busy_ff;
   assign b_valid = b_valid_ff;
   assign b_rsp.channel_good = b_good_ff;
   assign b_rsp.bin_count = b_read_ff ? cur : '0;

endmodule

[rtl/core/gilbert_elliott_loss_channel.sv]
// Two-state good/bad packet loss channel with a loss-burst histogram.
// Requests enter on req_valid/req_ready with an opcode, a random draw and a
// bin index; each request gives exactly one response on rsp_valid/rsp_ready
// carrying the channel state after the request and, for a read, the bin count.
// Thresholds are written on the csr port (index 0 good-to-bad, index 1
// bad-to-good) while no request is in flight, a rule for the user that the
// block does not enforce; they take effect at once. Each request passes the
// input, histogram read and response registers. One request is taken every
// cycle unless the response stalls or the clear runs; the histogram is one
// memory with one write and one registered read port, and the
// read-increment-write of a closing burst forwards its result to the request
// right behind it. After reset the histogram is swept to zero, one bin a
// cycle, with req_ready low; channel starts good with thresholds 0 and 10000.
// A stalled receiver holds the response register; the stages behind it fill
// and req_ready drops once the input register cannot move on.
module gilbert_elliott_loss_channel #(
   parameter int HIST_BINS = gel_pkg::HIST_BINS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  gel_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output gel_pkg::rsp_type                rsp_data,
   input  logic                            csr_write_enable,
   input  logic [gel_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gel_pkg::THRESH_W-1:0]    csr_write_data
);
   import gel_pkg::*;

   localparam int ADDR_W = (HIST_BINS > 1) ? $clog2(HIST_BINS) : 1;

   logic [THRESH_W-1:0] g2b_ff, b2g_ff;

   logic         a_valid_ff;
   req_type      a_req_ff;
   logic         c_valid_ff;
   rsp_type      c_rsp_ff;

   logic         c_ready, b_ready, a_ready;
   logic         a_adv, b_adv, accept;
   logic         clear_busy, b_valid;
   rsp_type      b_rsp;
   hist_cmd_type cmd;
   logic [ADDR_W-1:0] addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         g2b_ff <= '0;
         b2g_ff <= PROB_SCALE;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_GOOD_TO_BAD: g2b_ff <= csr_write_data;
            CSR_BAD_TO_GOOD: b2g_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign c_ready = !c_valid_ff || rsp_ready;
   assign b_adv = b_valid && c_ready;
   assign b_ready = !b_valid || c_ready;
   assign a_adv = a_valid_ff && b_ready;
   assign a_ready = !a_valid_ff || b_ready;
   assign req_ready = a_ready && !clear_busy;
   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (accept) begin
         a_valid_ff <= 1'b1;
      end else if (a_adv) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_req_ff <= req_data;
      end
   end

   gel_state #(
      .HIST_BINS(HIST_BINS),
      .ADDR_W(ADDR_W)
   ) u_state (
      .clock(clock),
      .reset(reset),
      .fire(a_adv),
      .req(a_req_ff),
      .good_to_bad_threshold(g2b_ff),
      .bad_to_good_threshold(b2g_ff),
      .cmd(cmd),
      .addr(addr)
   );

   gel_hist #(
      .HIST_BINS(HIST_BINS),
      .ADDR_W(ADDR_W)
   ) u_hist (
      .clock(clock),
      .reset(reset),
      .load(a_adv),
      .advance(b_adv),
      .cmd(cmd),
      .addr(addr),
      .clear_busy(clear_busy),
      .b_valid(b_valid),
      .b_rsp(b_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (b_adv) begin
         c_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         c_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (b_adv) begin
         c_rsp_ff <= b_rsp;
      end
   end

   assign rsp_valid = c_valid_ff;
   assign rsp_data = c_rsp_ff;

   // sweep runs with the pipeline empty
   assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !a_valid_ff && !b_valid && !c_valid_ff)
      else $error("request in flight during histogram clear");

   // a burst is only recorded when the channel comes back good
   assert property (@(posedge clock) disable iff (reset)
      a_adv && cmd.incr |-> cmd.good && !cmd.read)
      else $error("histogram bump without return to good");

   // a held response is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      c_valid_ff && !rsp_ready |=> c_valid_ff && $stable(c_rsp_ff))
      else $error("stalled response lost");

endmodule
